// ===== design/bfa_pkg.sv =====
package bfa_pkg;

    // Field widths fixed by the request and result formats.
    localparam int ADDR_W = 16;
    localparam int LEN_W  = 17;
    localparam int SUM_W  = 19;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_UNKNOWN = 2'd2
    } status_t;

    // Request kinds carried in tuser.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // One extent: header offset and payload length.
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] start;
    } extent_t;

    localparam int EXT_W = LEN_W + ADDR_W;

endpackage

// ===== design/bfa_ram.sv =====
module bfa_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 65
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/best_fit_free_list_allocator_unit.sv =====
// Best-fit allocator over one arena of byte offsets, with coalescing on free.
// Input channel (s_): tuser is the request kind (0 allocate, 1 free); tdata
// carries the requested payload size and the payload offset to free.
// Result channel (m_): one item per request with the payload offset, a status
// code and the payload bytes held after the request.
// Configuration: cfg_we with cfg_wdata sets the arena size and rebuilds the
// tables; write it only while the block is idle.
// Both tables sit in one-read, one-write RAMs with a registered read. An
// allocate scans all free extents and, when a whole extent is taken, shifts
// the tail of the table down. A free scans the held table, then the free
// table, then may shift the free table up or down, and moves the last held
// entry into the gap. One item is worked on at a time. After reset, and
// after every configuration write, the init state writes the first free
// extent before s_tready rises. A result waits in the output register while
// m_tready is low; the next item is still accepted and worked on, and its
// result then waits, with s_tready low, until the register drains.
module best_fit_free_list_allocator_unit #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16,
    parameter int ARENA_MAX    = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // req_size [15:0], addr [31:16]
    input  logic        s_tuser,   // req_type [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // addr_out [15:0], status [17:16], used_bytes [34:18]
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata
);

    localparam int FREE_DEPTH = MAX_BLOCKS + 1;
    localparam int FI_W  = $clog2(FREE_DEPTH);
    localparam int CNT_W = $clog2(FREE_DEPTH + 1);
    localparam int HI_W  = $clog2(MAX_BLOCKS);
    localparam int HC_W  = $clog2(MAX_BLOCKS + 1);
    localparam int ARENA_LOW  = (2 * HEADER_BYTES > 32) ? 2 * HEADER_BYTES : 32;
    localparam int ARENA_HIGH = (ARENA_MAX < 65536) ? ARENA_MAX : 65536;
    localparam int LW = bfa_pkg::LEN_W;
    localparam int AW = bfa_pkg::ADDR_W;
    localparam int SW = bfa_pkg::SUM_W;
    localparam logic [SW-1:0] HDR_S = SW'(HEADER_BYTES);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_A_SCAN, S_A_DEC, S_SHDN, S_H_SCAN,
        S_F_SCAN, S_F_DEC, S_SHUP, S_HMOV_RD, S_HMOV_WR, S_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [LW-1:0]           arena_reg, arena_next;
    logic [CNT_W-1:0]        free_count_reg, free_count_next;
    logic [HC_W-1:0]         held_count_reg, held_count_next;
    logic [LW-1:0]           bytes_reg, bytes_next;
    logic [CNT_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic                    vld_reg, vld_next;
    logic [CNT_W-1:0]        dat_idx_reg, dat_idx_next;
    logic                    type_reg, type_next;
    logic [AW-1:0]           size_reg, size_next;
    logic [AW-1:0]           addr_reg, addr_next;
    logic                    found_reg, found_next;
    logic [CNT_W-1:0]        best_idx_reg, best_idx_next;
    bfa_pkg::extent_t        best_reg, best_next;
    logic [HI_W-1:0]         hj_reg, hj_next;
    bfa_pkg::extent_t        hent_reg, hent_next;
    logic [CNT_W-1:0]        pos_reg, pos_next;
    logic                    pos_done_reg, pos_done_next;
    bfa_pkg::extent_t        prev_reg, prev_next;
    bfa_pkg::extent_t        nxt_reg, nxt_next;
    logic [AW-1:0]           res_addr_reg, res_addr_next;
    bfa_pkg::status_t        res_status_reg, res_status_next;
    logic                    m_valid_reg, m_valid_next;
    logic [AW-1:0]           m_addr_reg, m_addr_next;
    bfa_pkg::status_t        m_status_reg, m_status_next;
    logic [LW-1:0]           m_used_reg, m_used_next;

    // Memory ports.
    logic                    f_we;
    logic [FI_W-1:0]         f_waddr, f_raddr;
    bfa_pkg::extent_t        f_wdata, f_rdata;
    logic                    h_we;
    logic [HI_W-1:0]         h_waddr, h_raddr;
    bfa_pkg::extent_t        h_wdata, h_rdata;

    // Decision terms.
    logic [SW-1:0]           size_hdr;
    logic                    take_whole;
    logic [LW-1:0]           take_len;
    logic                    join_next, join_prev;
    logic [SW-1:0]           cfg_sat;

    bfa_ram #(.WIDTH(bfa_pkg::EXT_W), .DEPTH(FREE_DEPTH)) u_free_ram (
        .aclk(aclk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    bfa_ram #(.WIDTH(bfa_pkg::EXT_W), .DEPTH(MAX_BLOCKS)) u_held_ram (
        .aclk(aclk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_used_reg, m_status_reg, m_addr_reg};

    // Fit and merge terms from the latched scan results.
    always_comb begin
        size_hdr   = SW'(size_reg) + HDR_S;
        take_whole = SW'(best_reg.len) <= size_hdr;
        take_len   = take_whole ? best_reg.len : LW'(size_reg);
        join_next  = pos_done_reg &&
                     (SW'(hent_reg.start) + HDR_S + SW'(hent_reg.len) == SW'(nxt_reg.start));
        join_prev  = (pos_reg != '0) &&
                     (SW'(prev_reg.start) + HDR_S + SW'(prev_reg.len) == SW'(hent_reg.start));
        if (SW'(cfg_wdata) < SW'(ARENA_LOW)) begin
            cfg_sat = SW'(ARENA_LOW);
        end else if (SW'(cfg_wdata) > SW'(ARENA_HIGH)) begin
            cfg_sat = SW'(ARENA_HIGH);
        end else begin
            cfg_sat = SW'(cfg_wdata);
        end
    end

    // Sequencer: scans, shifts and table updates.
    always_comb begin
        state_next      = state_reg;
        arena_next      = arena_reg;
        free_count_next = free_count_reg;
        held_count_next = held_count_reg;
        bytes_next      = bytes_reg;
        rd_ptr_next     = rd_ptr_reg;
        vld_next        = 1'b0;
        dat_idx_next    = dat_idx_reg;
        type_next       = type_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        hj_next         = hj_reg;
        hent_next       = hent_reg;
        pos_next        = pos_reg;
        pos_done_next   = pos_done_reg;
        prev_next       = prev_reg;
        nxt_next        = nxt_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_addr_next     = m_addr_reg;
        m_status_next   = m_status_reg;
        m_used_next     = m_used_reg;
        f_we    = 1'b0;
        f_waddr = '0;
        f_wdata = '0;
        f_raddr = FI_W'(rd_ptr_reg);
        h_we    = 1'b0;
        h_waddr = '0;
        h_wdata = '0;
        h_raddr = HI_W'(rd_ptr_reg);

        // The output register drains independently.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT: begin
                f_we            = 1'b1;
                f_waddr         = '0;
                f_wdata.start   = '0;
                f_wdata.len     = arena_reg - LW'(HEADER_BYTES);
                free_count_next = CNT_W'(1);
                held_count_next = '0;
                bytes_next      = '0;
                state_next      = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    type_next     = s_tuser;
                    size_next     = s_tdata[15:0];
                    addr_next     = s_tdata[31:16];
                    rd_ptr_next   = '0;
                    found_next    = 1'b0;
                    res_addr_next = '0;
                    if (s_tuser == bfa_pkg::REQ_FREE) begin
                        state_next = S_H_SCAN;
                    end else if (held_count_reg >= HC_W'(MAX_BLOCKS)) begin
                        res_status_next = bfa_pkg::ST_NOFIT;
                        state_next      = S_OUT;
                    end else begin
                        state_next = S_A_SCAN;
                    end
                end
            end
            S_A_SCAN: begin
                if (rd_ptr_reg < free_count_reg) begin
                    vld_next     = 1'b1;
                    dat_idx_next = rd_ptr_reg;
                    rd_ptr_next  = rd_ptr_reg + 1'b1;
                end
                if (vld_reg && f_rdata.len >= LW'(size_reg) &&
                    (!found_reg || f_rdata.len < best_reg.len)) begin
                    found_next    = 1'b1;
                    best_next     = f_rdata;
                    best_idx_next = dat_idx_reg;
                end
                if (!vld_reg && rd_ptr_reg >= free_count_reg) begin
                    if (found_reg) begin
                        state_next = S_A_DEC;
                    end else begin
                        res_status_next = bfa_pkg::ST_NOFIT;
                        state_next      = S_OUT;
                    end
                end
            end
            S_A_DEC: begin
                h_we            = 1'b1;
                h_waddr         = HI_W'(held_count_reg);
                h_wdata.start   = best_reg.start;
                h_wdata.len     = take_len;
                held_count_next = held_count_reg + 1'b1;
                bytes_next      = bytes_reg + take_len;
                res_addr_next   = best_reg.start + AW'(HEADER_BYTES);
                res_status_next = bfa_pkg::ST_OK;
                if (take_whole) begin
                    rd_ptr_next = best_idx_reg + 1'b1;
                    state_next  = S_SHDN;
                end else begin
                    f_we          = 1'b1;
                    f_waddr       = FI_W'(best_idx_reg);
                    f_wdata.start = best_reg.start + AW'(HEADER_BYTES) + size_reg;
                    f_wdata.len   = best_reg.len - LW'(size_reg) - LW'(HEADER_BYTES);
                    state_next    = S_OUT;
                end
            end
            S_SHDN: begin
                // Close the gap: entry k+1 moves to k.
                if (rd_ptr_reg < free_count_reg) begin
                    vld_next     = 1'b1;
                    dat_idx_next = rd_ptr_reg;
                    rd_ptr_next  = rd_ptr_reg + 1'b1;
                end
                if (vld_reg) begin
                    f_we    = 1'b1;
                    f_waddr = FI_W'(dat_idx_reg - 1'b1);
                    f_wdata = f_rdata;
                end
                if (!vld_reg && rd_ptr_reg >= free_count_reg) begin
                    free_count_next = free_count_reg - 1'b1;
                    state_next = (type_reg == bfa_pkg::REQ_FREE) ? S_HMOV_RD : S_OUT;
                end
            end
            S_H_SCAN: begin
                if (rd_ptr_reg < CNT_W'(held_count_reg)) begin
                    vld_next     = 1'b1;
                    dat_idx_next = rd_ptr_reg;
                    rd_ptr_next  = rd_ptr_reg + 1'b1;
                end
                if (vld_reg && !found_reg &&
                    SW'(h_rdata.start) + HDR_S == SW'(addr_reg)) begin
                    found_next = 1'b1;
                    hj_next    = HI_W'(dat_idx_reg);
                    hent_next  = h_rdata;
                end
                if (!vld_reg && rd_ptr_reg >= CNT_W'(held_count_reg)) begin
                    if (addr_reg == '0 || !found_reg) begin
                        res_status_next = bfa_pkg::ST_UNKNOWN;
                        state_next      = S_OUT;
                    end else begin
                        rd_ptr_next   = '0;
                        pos_next      = '0;
                        pos_done_next = 1'b0;
                        state_next    = S_F_SCAN;
                    end
                end
            end
            S_F_SCAN: begin
                // Find the first extent at or above the freed block.
                if (rd_ptr_reg < free_count_reg) begin
                    vld_next     = 1'b1;
                    dat_idx_next = rd_ptr_reg;
                    rd_ptr_next  = rd_ptr_reg + 1'b1;
                end
                if (vld_reg && !pos_done_reg) begin
                    if (f_rdata.start < hent_reg.start) begin
                        prev_next = f_rdata;
                        pos_next  = dat_idx_reg + 1'b1;
                    end else begin
                        pos_done_next = 1'b1;
                        nxt_next      = f_rdata;
                        pos_next      = dat_idx_reg;
                    end
                end
                if (!vld_reg && rd_ptr_reg >= free_count_reg) begin
                    state_next = S_F_DEC;
                end
            end
            S_F_DEC: begin
                res_status_next = bfa_pkg::ST_OK;
                if (join_prev && join_next) begin
                    f_we          = 1'b1;
                    f_waddr       = FI_W'(pos_reg - 1'b1);
                    f_wdata.start = prev_reg.start;
                    f_wdata.len   = prev_reg.len + LW'(HEADER_BYTES) + hent_reg.len +
                                    LW'(HEADER_BYTES) + nxt_reg.len;
                    rd_ptr_next   = pos_reg + 1'b1;
                    state_next    = S_SHDN;
                end else if (join_prev) begin
                    f_we          = 1'b1;
                    f_waddr       = FI_W'(pos_reg - 1'b1);
                    f_wdata.start = prev_reg.start;
                    f_wdata.len   = prev_reg.len + LW'(HEADER_BYTES) + hent_reg.len;
                    state_next    = S_HMOV_RD;
                end else if (join_next) begin
                    f_we          = 1'b1;
                    f_waddr       = FI_W'(pos_reg);
                    f_wdata.start = hent_reg.start;
                    f_wdata.len   = nxt_reg.len + LW'(HEADER_BYTES) + hent_reg.len;
                    state_next    = S_HMOV_RD;
                end else if (free_count_reg >= CNT_W'(FREE_DEPTH)) begin
                    res_status_next = bfa_pkg::ST_NOFIT;
                    state_next      = S_OUT;
                end else begin
                    rd_ptr_next = free_count_reg;
                    state_next  = S_SHUP;
                end
            end
            S_SHUP: begin
                // Open a slot: entry k moves to k+1, from the top down.
                f_raddr = FI_W'(rd_ptr_reg - 1'b1);
                if (rd_ptr_reg > pos_reg) begin
                    vld_next     = 1'b1;
                    dat_idx_next = rd_ptr_reg - 1'b1;
                    rd_ptr_next  = rd_ptr_reg - 1'b1;
                end
                if (vld_reg) begin
                    f_we    = 1'b1;
                    f_waddr = FI_W'(dat_idx_reg + 1'b1);
                    f_wdata = f_rdata;
                end else if (rd_ptr_reg == pos_reg) begin
                    f_we            = 1'b1;
                    f_waddr         = FI_W'(pos_reg);
                    f_wdata         = hent_reg;
                    free_count_next = free_count_reg + 1'b1;
                    state_next      = S_HMOV_RD;
                end
            end
            S_HMOV_RD: begin
                h_raddr    = HI_W'(held_count_reg - 1'b1);
                state_next = S_HMOV_WR;
            end
            S_HMOV_WR: begin
                h_we            = 1'b1;
                h_waddr         = hj_reg;
                h_wdata         = h_rdata;
                held_count_next = held_count_reg - 1'b1;
                bytes_next      = (bytes_reg >= hent_reg.len) ? bytes_reg - hent_reg.len : '0;
                res_status_next = bfa_pkg::ST_OK;
                state_next      = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_addr_next   = res_addr_reg;
                    m_status_next = res_status_reg;
                    m_used_next   = bytes_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase

        // A configuration write rebuilds the tables.
        if (cfg_we) begin
            arena_next = LW'(cfg_sat);
            state_next = S_INIT;
        end
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_INIT;
            arena_reg      <= LW'(ARENA_HIGH);
            free_count_reg <= CNT_W'(1);
            held_count_reg <= '0;
            bytes_reg      <= '0;
            vld_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            arena_reg      <= arena_next;
            free_count_reg <= free_count_next;
            held_count_reg <= held_count_next;
            bytes_reg      <= bytes_next;
            vld_reg        <= vld_next;
            m_valid_reg    <= m_valid_next;
        end
        rd_ptr_reg     <= rd_ptr_next;
        dat_idx_reg    <= dat_idx_next;
        type_reg       <= type_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        found_reg      <= found_next;
        best_idx_reg   <= best_idx_next;
        best_reg       <= best_next;
        hj_reg         <= hj_next;
        hent_reg       <= hent_next;
        pos_reg        <= pos_next;
        pos_done_reg   <= pos_done_next;
        prev_reg       <= prev_next;
        nxt_reg        <= nxt_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_addr_reg     <= m_addr_next;
        m_status_reg   <= m_status_next;
        m_used_reg     <= m_used_next;
    end

    // The free table never holds more extents than it has entries.
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_count_reg <= CNT_W'(FREE_DEPTH))
        else $error("free extent count out of range");

    // The held table never holds more blocks than it has entries.
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg <= HC_W'(MAX_BLOCKS))
        else $error("held block count out of range");

    // An accepted item leaves the idle state unless configuration intervenes.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !cfg_we) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start work");

    // A failed request never reports an offset.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != bfa_pkg::ST_OK) |-> (m_addr_reg == '0))
        else $error("failed request carries an offset");

endmodule
